FILE: rtl/tcw_pkg.sv
// tcw_pkg: shared constants, op codes and transaction types for the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths fixed by the port list
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CH_W   = 8;
    localparam int CELL_W = 16;
    localparam int REQ_W  = 2;

    // Queue depths, powers of two
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Characters and attributes
    localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CH_W-1:0] RESET_ATTR   = 8'h0F;

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Internal command codes after classification
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  ch;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  line;
        logic [COL_W-1:0]  col;
    } res_t;

endpackage

FILE: rtl/tcw_front.sv
// tcw_front: input side. Classifies requests and holds them in a short command queue.
// Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [CH_W-1:0]   char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    input  logic              eng_init,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_take
);

    cmd_t                 q_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0]  cnt_reg, cnt_next;
    cmd_t                 in_cmd;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        in_cmd.ch  = char_code;
        in_cmd.row = read_row;
        in_cmd.col = read_col;
        unique case (req_type)
            REQ_PUT:
            begin
                if (char_code == CH_NEWLINE)
                    in_cmd.op = OP_NEWLINE;
                else if (char_code == CH_BACKSPACE)
                    in_cmd.op = OP_BACKSPACE;
                else
                    in_cmd.op = OP_PUT;
            end
            REQ_CLEAR: in_cmd.op = OP_CLEAR;
            REQ_READ:
            begin
                // reads off the grid return zero, same as an unused code
                if (int'(read_row) < ROWS && int'(read_col) < COLUMNS)
                    in_cmd.op = OP_READ;
                else
                    in_cmd.op = OP_NOP;
            end
            default: in_cmd.op = OP_NOP;
        endcase
    end

    // nothing is taken while the screen is being blanked after reset
    assign full      = eng_init || (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

FILE: rtl/tcw_engine.sv
// tcw_engine: back side. Owns the screen memory, cursor, scroll offset and blanking sweeps.
// Depends on tcw_pkg.
module tcw_engine
    import tcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CH_W-1:0]  cfg_data,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_take,
    input  logic             res_full,
    output logic             res_push,
    output res_t             res_entry,
    output logic             eng_init
);

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    // physical row that holds logical row 0
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;
    logic [CH_W-1:0]   sweep_attr_reg, sweep_attr_next;
    logic [CH_W-1:0]   color_reg, color_next;

    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [ROW_W:0]    cur_sum;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W:0]    rd_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [COL_W-1:0]  wr_col;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] top_base;
    logic [ROW_W-1:0]  top_inc;
    logic              at_last_line;

    // logical to physical row through the scroll offset
    always_comb
    begin
        cur_sum  = {1'b0, line_reg} + {1'b0, top_reg};
        cur_phys = (int'(cur_sum) >= ROWS) ? ROW_W'(int'(cur_sum) - ROWS) : cur_sum[ROW_W-1:0];
        rd_sum   = {1'b0, cmd.row} + {1'b0, top_reg};
        rd_phys  = (int'(rd_sum) >= ROWS) ? ROW_W'(int'(rd_sum) - ROWS) : rd_sum[ROW_W-1:0];
        wr_col   = (cmd.op == OP_BACKSPACE) ? col_reg - 1'b1 : col_reg;
        cur_addr = ADDR_W'(ADDR_W'(cur_phys) * ADDR_W'(COLUMNS)) + ADDR_W'(wr_col);
        rd_addr  = ADDR_W'(ADDR_W'(rd_phys) * ADDR_W'(COLUMNS)) + ADDR_W'(cmd.col);
        top_base = ADDR_W'(ADDR_W'(top_reg) * ADDR_W'(COLUMNS));
        top_inc  = (int'(top_reg) == ROWS - 1) ? '0 : top_reg + 1'b1;
        at_last_line = (int'(line_reg) == ROWS - 1);
    end

    always_comb
    begin
        state_next      = state_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        sweep_attr_next = sweep_attr_reg;
        color_next      = cfg_we ? cfg_data : color_reg;
        cmd_take        = 1'b0;
        res_push        = 1'b0;
        res_entry       = '0;
        mem_we          = 1'b0;
        mem_waddr       = cur_addr;
        mem_wdata       = {color_reg, cmd.ch};
        rd_en           = 1'b0;

        unique case (state_reg) inside
            S_INIT, S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = {sweep_attr_reg, CH_SPACE};
                if (sweep_addr_reg == sweep_end_reg)
                    state_next = S_IDLE;
                else
                    sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            S_READ:
            begin
                res_push            = 1'b1;
                res_entry.cell_data = rdata_reg;
                res_entry.line      = line_reg;
                res_entry.col       = col_reg;
                state_next          = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op) inside
                        OP_PUT, OP_NEWLINE:
                        begin
                            if (cmd.op == OP_PUT)
                                mem_we = 1'b1;
                            if (cmd.op == OP_NEWLINE || int'(col_reg) == COLUMNS - 1)
                            begin
                                col_next = '0;
                                if (!at_last_line)
                                    line_next = line_reg + 1'b1;
                                else
                                begin
                                    // scroll: old top row becomes the blank bottom row
                                    top_next        = top_inc;
                                    sweep_addr_next = top_base;
                                    sweep_end_next  = top_base + ADDR_W'(COLUMNS - 1);
                                    sweep_attr_next = color_reg;
                                    state_next      = S_SWEEP;
                                end
                            end
                            else
                                col_next = col_reg + 1'b1;
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {color_reg, CH_SPACE};
                                col_next  = col_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            line_next       = '0;
                            col_next        = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_end_next  = ADDR_W'(CELLS - 1);
                            sweep_attr_next = color_reg;
                            state_next      = S_SWEEP;
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cmd.op != OP_READ)
                    begin
                        res_push       = 1'b1;
                        res_entry.line = line_next;
                        res_entry.col  = col_next;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign eng_init = (state_reg == S_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            line_reg       <= '0;
            col_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= ADDR_W'(CELLS - 1);
            sweep_attr_reg <= RESET_ATTR;
            color_reg      <= RESET_ATTR;
        end
        else
        begin
            state_reg      <= state_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            sweep_attr_reg <= sweep_attr_next;
            color_reg      <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rdata_reg <= cell_mem[rd_addr];
    end

endmodule

FILE: rtl/tcw_rq.sv
// tcw_rq: result queue between the engine and the output channel.
// Depends on tcw_pkg.
module tcw_rq
    import tcw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  res_push,
    input  res_t  res_entry,
    output logic  res_full,
    output logic  empty,
    input  logic  pop,
    output res_t  head
);

    res_t                 q_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign res_full = (cnt_reg == RQ_CNT_W'(RQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= res_entry;
    end

endmodule

FILE: rtl/text_console_writer.sv
// text_console_writer: top level of the text-mode console engine.
// Depends on tcw_pkg, tcw_front, tcw_engine, tcw_rq.
//
//  channel   handshake              payload
//  request   push / full            req_type, char_code, read_row, read_col
//  result    pop / empty            cell_value, line_now, column_now
//  config    cfg_valid / cfg_ready  cfg_data (text color attribute)
//
// Put, newline without scroll, backspace and unused codes finish in the engine's idle
// state; a read also passes the read state (registered screen RAM port). A scroll
// blanks one row and clear blanks the whole RAM, one cell per cycle.
// After reset the same sweep blanks the RAM with full held high.
// A two-entry command queue and a two-entry result queue let each side stall on its own.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [CH_W-1:0]   char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    output logic              empty,
    input  logic              pop,
    output logic [CELL_W-1:0] cell_value,
    output logic [ROW_W-1:0]  line_now,
    output logic [COL_W-1:0]  column_now,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CH_W-1:0]   cfg_data
);

    logic  eng_init;
    logic  cmd_valid;
    cmd_t  cmd;
    logic  cmd_take;
    logic  res_full;
    logic  res_push;
    res_t  res_entry;
    res_t  head;
    logic  cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .eng_init  (eng_init),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tcw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_entry (res_entry),
        .eng_init  (eng_init)
    );

    tcw_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_entry (res_entry),
        .res_full  (res_full),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign cell_value = head.cell_data;
    assign line_now   = head.line;
    assign column_now = head.col;

endmodule

FILE: tb/text_console_writer_test.sv
// Self-checking testbench for text_console_writer: directed steps, then random text traffic.
// Depends on tcw_pkg and the text_console_writer RTL; keeps its own shadow of screen and cursor.
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 2 * CELLS + 100;
    localparam int RANDOM_CLEARS = 30;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 317;

    // One request; typed rows carry their expected report, the rest use the shadow model
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CH_W-1:0]   ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              typed;
        logic [CELL_W-1:0] cell_v;
        logic [ROW_W-1:0]  ln;
        logic [COL_W-1:0]  cl;
    } step_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_v;
        logic [ROW_W-1:0]  ln;
        logic [COL_W-1:0]  cl;
    } report_t;

    localparam step_t OPENING_STEPS [21] = '{
        '{REQ_READ,   8'h00,        5'd0,  7'd0,   1'b1, 16'h0F20, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd24, 7'd79,  1'b1, 16'h0F20, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd25, 7'd0,   1'b1, 16'h0000, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd0,  7'd80,  1'b1, 16'h0000, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0},
        '{REQ_PUT,    8'h41,        5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd1},
        '{REQ_PUT,    8'hFF,        5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd2},
        '{REQ_PUT,    8'h00,        5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd3},
        '{REQ_READ,   8'h00,        5'd0,  7'd0,   1'b1, 16'h0F41, 5'd0, 7'd3},
        '{REQ_READ,   8'h00,        5'd0,  7'd1,   1'b1, 16'h0FFF, 5'd0, 7'd3},
        '{REQ_PUT,    CH_BACKSPACE, 5'd1,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd2},
        '{REQ_READ,   8'h00,        5'd0,  7'd2,   1'b1, 16'h0F20, 5'd0, 7'd2},
        '{REQ_PUT,    CH_NEWLINE,   5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0},
        '{REQ_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0},
        '{REQ_UNUSED, CH_NEWLINE,   5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0},
        '{REQ_PUT,    8'h0D,        5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd1},
        '{REQ_READ,   8'h00,        5'd1,  7'd0,   1'b1, 16'h0F0D, 5'd1, 7'd1},
        '{REQ_CLEAR,  8'h41,        5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd0,  7'd0,   1'b1, 16'h0F20, 5'd0, 7'd0},
        '{REQ_READ,   8'h00,        5'd1,  7'd0,   1'b0, 16'h0000, 5'd0, 7'd0},
        '{REQ_PUT,    8'h7F,        5'd0,  7'd0,   1'b0, 16'h0000, 5'd0, 7'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [REQ_W-1:0]  req_type = '0;
    logic [CH_W-1:0]   char_code = '0;
    logic [ROW_W-1:0]  read_row = '0;
    logic [COL_W-1:0]  read_col = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  line_now;
    logic [COL_W-1:0]  column_now;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CH_W-1:0]   cfg_data = '0;

    // Shadow screen, cursor and attribute
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                cur_line;
    int                cur_col;
    logic [CH_W-1:0]   text_attr;

    report_t awaited_reports [$];

    int  mismatches = 0;
    int  requests_sent = 0;
    int  reports_checked = 0;
    int  reads_sent = 0;
    int  clears_sent = 0;
    int  scrolls_seen = 0;
    int  colors_used = 0;
    int  cycle_count = 0;
    int  clears_left = RANDOM_CLEARS;
    int  long_run = 0;
    int  pop_hold = 0;
    bit  no_idle = 1'b0;

    text_console_writer DUT (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(input int row, input int col);
        return ADDR_W'(row * COLUMNS + col);
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[ADDR_W'(i)] = {text_attr, CH_SPACE};
        cur_line = 0;
        cur_col = 0;
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        cur_line++;
        if (cur_line >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_cells[ADDR_W'(i)] = shadow_cells[ADDR_W'(i + COLUMNS)];
            for (int c = 0; c < COLUMNS; c++)
                shadow_cells[cell_index(ROWS - 1, c)] = {text_attr, CH_SPACE};
            cur_line = ROWS - 1;
            scrolls_seen++;
        end
    endfunction

    // Applies one request to the shadow state and returns the report it should produce
    function automatic report_t console_step(input step_t s);
        report_t rep;
        rep = '0;
        case (s.req)
            REQ_PUT:
            begin
                if (s.ch == CH_NEWLINE)
                    line_feed();
                else if (s.ch == CH_BACKSPACE)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        shadow_cells[cell_index(cur_line, cur_col)] = {text_attr, CH_SPACE};
                    end
                end
                else
                begin
                    shadow_cells[cell_index(cur_line, cur_col)] = {text_attr, s.ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        line_feed();
                end
            end
            REQ_CLEAR:
                blank_screen();
            REQ_READ:
            begin
                if (int'(s.row) < ROWS && int'(s.col) < COLUMNS)
                    rep.cell_v = shadow_cells[cell_index(int'(s.row), int'(s.col))];
            end
            default: ;
        endcase
        rep.ln = cur_line[ROW_W-1:0];
        rep.cl = cur_col[COL_W-1:0];
        return rep;
    endfunction

    // Text lines of random content; some long runs to force wraps, plus backspaces, reads, clears and noise
    function automatic step_t random_step();
        step_t s;
        int    pick;
        s = '0;
        s.req = REQ_PUT;
        s.row = ROW_W'($urandom_range(0, 31));
        s.col = COL_W'($urandom_range(0, 127));
        if ($urandom_range(0, 9) == 0)
            s.ch = CH_W'($urandom_range(0, 255));
        else
            s.ch = CH_W'($urandom_range(8'h20, 8'h7E));
        if (long_run == 0 && $urandom_range(0, 299) == 0)
            long_run = $urandom_range(150, 300);
        if (long_run > 0)
            long_run--;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            ;
        else if (pick < 68)
        begin
            if (long_run == 0)
                s.ch = CH_NEWLINE;
        end
        else if (pick < 76)
            s.ch = CH_BACKSPACE;
        else if (pick < 93)
        begin
            s.req = REQ_READ;
            if ($urandom_range(0, 9) != 0)
            begin
                s.row = ROW_W'($urandom_range(0, ROWS - 1));
                s.col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (pick < 96)
            s.req = REQ_UNUSED;
        else if (pick < 97 && clears_left > 0)
        begin
            s.req = REQ_CLEAR;
            clears_left--;
        end
        return s;
    endfunction

    task automatic send_request(input step_t s);
        int      gap;
        report_t rep;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        req_type  <= s.req;
        char_code <= s.ch;
        read_row  <= s.row;
        read_col  <= s.col;
        do @(posedge clk); while (full);
        rep = console_step(s);
        if (s.typed)
            rep = '{s.cell_v, s.ln, s.cl};
        awaited_reports.push_back(rep);
        requests_sent++;
        if (s.req == REQ_READ)
            reads_sent++;
        if (s.req == REQ_CLEAR)
            clears_sent++;
    endtask

    // Only called with push low; waits until every report is back
    task automatic set_text_color(input logic [CH_W-1:0] value);
        while (awaited_reports.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_attr = value;
        colors_used++;
    endtask

    task automatic check_field(input string name, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: check each popped transaction, then maybe stall
    always @(posedge clk)
    begin
        report_t want;
        if (pop && !empty)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("result with no request outstanding: cell 0x%0h line %0d col %0d",
                       cell_value, line_now, column_now);
                mismatches++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("cell_value", want.cell_v, cell_value);
                check_field("line_now", CELL_W'(want.ln), CELL_W'(line_now));
                check_field("column_now", CELL_W'(want.cl), CELL_W'(column_now));
                reports_checked++;
            end
            pop_hold = pick_gap();
        end
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
            pop <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d reports outstanding",
                 cycle_count, awaited_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [CH_W-1:0] color;
        text_attr = RESET_ATTR;
        blank_screen();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_STEPS[i])
            send_request(OPENING_STEPS[i]);
        push <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                3:       color = 8'h80;
                5:       color = RESET_ATTR;
                default: color = CH_W'($urandom_range(0, 255));
            endcase
            set_text_color(color);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 64 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_request(random_step());
            end
            push <= 1'b0;
        end

        no_idle = 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d reads, %0d clears), %0d scrolls, %0d text colors.",
                 requests_sent, reads_sent, clears_sent, scrolls_seen, colors_used);
        $display("Checked %0d reports in %0d cycles, %0d mismatches.",
                 reports_checked, cycle_count, mismatches);
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
